// ===== sv/telemetry_frame_parser_unit_macros.svh =====
// assertion macros of the telemetry frame parser, used by tfp_parser
`ifndef TELEMETRY_FRAME_PARSER_UNIT_MACROS_SVH
`define TELEMETRY_FRAME_PARSER_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define TFP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/tfp_pkg.sv =====
// types and constants of the telemetry frame parser
`timescale 1ns / 1ps

package tfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 16;

  localparam logic [ByteW-1:0] OverheadBytes = 8'd6;
  localparam logic [ByteW-1:0] StartByteRst  = 8'd153;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 3;

  typedef enum logic [2:0] {
    ST_WAIT    = 3'd0,
    ST_LEN     = 3'd1,
    ST_ACID    = 3'd2,
    ST_MSGID   = 3'd3,
    ST_PAYLOAD = 3'd4,
    ST_CK1     = 3'd5,
    ST_CK2     = 3'd6
  } parse_state_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_BYTE   = 3'd1,
    EV_GOOD   = 3'd2,
    EV_CKERR  = 3'd3,
    EV_OVRN   = 3'd4,
    EV_BADLEN = 3'd5
  } event_e;

  typedef struct packed {
    logic             action;
    logic [ByteW-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_e           event_res;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] aircraft_id;
    logic [ByteW-1:0] message_id;
    logic [ByteW-1:0] payload_length;
    logic             pending;
    logic [CntW-1:0]  error_total;
    logic [CntW-1:0]  overrun_total;
  } result_t;

endpackage

// ===== sv/tfp_in_reg.sv =====
// input register stage of the telemetry frame parser
`timescale 1ns / 1ps

module tfp_in_reg import tfp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  out_ready_i,
  output logic  fire_o,
  output item_t item_o
);

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  assign fire_o     = vld_q && out_ready_i;
  assign in_ready_o = !vld_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign item_o     = item_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (fire_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ===== sv/tfp_parser.sv =====
// frame parser state, checksum sums, counters and per-item result logic
`timescale 1ns / 1ps
`include "telemetry_frame_parser_unit_macros.svh"

module tfp_parser import tfp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ByteW-1:0] cfg_wdata_i,
  input  logic             fire_i,
  input  item_t            item_i,
  output result_t          res_o
);

  parse_state_e     state_q, state_d;
  logic [ByteW-1:0] start_q;
  logic [ByteW-1:0] sum1_q, sum1_d, sum2_q, sum2_d;
  logic [ByteW-1:0] len_q, len_d, count_q, count_d;
  logic [ByteW-1:0] acid_q, acid_d, msgid_q, msgid_d;
  logic             pending_q, pending_d;
  logic [CntW-1:0]  err_q, err_d, ovr_q, ovr_d;
  logic [ByteW-1:0] sum1_add, sum2_add, count_inc;
  logic [ByteW-1:0] rx;
  logic             err_inc, ovr_inc;
  event_e           ev;
  logic [ByteW-1:0] pb, pi;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign rx        = item_i.rx_byte;
  assign sum1_add  = sum1_q + rx;
  assign sum2_add  = sum2_q + sum1_add;
  assign count_inc = count_q + 1'b1;

  // next state
  always_comb begin
    state_d   = state_q;
    sum1_d    = sum1_q;
    sum2_d    = sum2_q;
    len_d     = len_q;
    count_d   = count_q;
    acid_d    = acid_q;
    msgid_d   = msgid_q;
    pending_d = pending_q;
    err_inc   = 1'b0;
    ovr_inc   = 1'b0;
    if (fire_i) begin
      if (item_i.action) begin
        pending_d = 1'b0;
      end else begin
        case (state_q)
          ST_LEN: begin
            if (pending_q) begin
              ovr_inc = 1'b1;
              err_inc = 1'b1;
              state_d = ST_WAIT;
            end else if (rx < OverheadBytes) begin
              err_inc = 1'b1;
              state_d = ST_WAIT;
            end else begin
              len_d   = rx - OverheadBytes;
              count_d = '0;
              sum1_d  = sum1_add;
              sum2_d  = sum2_add;
              state_d = ST_ACID;
            end
          end
          ST_ACID: begin
            acid_d  = rx;
            sum1_d  = sum1_add;
            sum2_d  = sum2_add;
            state_d = ST_MSGID;
          end
          ST_MSGID: begin
            msgid_d = rx;
            sum1_d  = sum1_add;
            sum2_d  = sum2_add;
            state_d = (len_q == '0) ? ST_CK1 : ST_PAYLOAD;
          end
          ST_PAYLOAD: begin
            count_d = count_inc;
            sum1_d  = sum1_add;
            sum2_d  = sum2_add;
            if (count_inc == len_q) begin
              state_d = ST_CK1;
            end
          end
          ST_CK1: begin
            if (rx != sum1_q) begin
              err_inc = 1'b1;
              state_d = ST_WAIT;
            end else begin
              state_d = ST_CK2;
            end
          end
          ST_CK2: begin
            if (rx != sum2_q) begin
              err_inc = 1'b1;
            end else begin
              pending_d = 1'b1;
            end
            state_d = ST_WAIT;
          end
          default: begin
            state_d = ST_WAIT;
            if (rx == start_q) begin
              sum1_d  = start_q;
              sum2_d  = start_q;
              state_d = ST_LEN;
            end
          end
        endcase
      end
    end
    err_d = err_inc ? sat_inc(err_q) : err_q;
    ovr_d = ovr_inc ? sat_inc(ovr_q) : ovr_q;
  end

  // per-item outputs
  always_comb begin
    ev = EV_NONE;
    pb = '0;
    pi = '0;
    if (!item_i.action) begin
      case (state_q)
        ST_LEN: begin
          if (pending_q) begin
            ev = EV_OVRN;
          end else if (rx < OverheadBytes) begin
            ev = EV_BADLEN;
          end
        end
        ST_PAYLOAD: begin
          ev = EV_BYTE;
          pb = rx;
          pi = count_q;
        end
        ST_CK1: begin
          if (rx != sum1_q) begin
            ev = EV_CKERR;
          end
        end
        ST_CK2: begin
          ev = (rx != sum2_q) ? EV_CKERR : EV_GOOD;
        end
        default: begin
          ev = EV_NONE;
        end
      endcase
    end
    res_o.event_res      = ev;
    res_o.payload_byte   = pb;
    res_o.payload_index  = pi;
    res_o.aircraft_id    = acid_d;
    res_o.message_id     = msgid_d;
    res_o.payload_length = len_d;
    res_o.pending        = pending_d;
    res_o.error_total    = err_d;
    res_o.overrun_total  = ovr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_WAIT;
      start_q   <= StartByteRst;
      sum1_q    <= '0;
      sum2_q    <= '0;
      len_q     <= '0;
      count_q   <= '0;
      acid_q    <= '0;
      msgid_q   <= '0;
      pending_q <= 1'b0;
      err_q     <= '0;
      ovr_q     <= '0;
    end else begin
      state_q   <= state_d;
      sum1_q    <= sum1_d;
      sum2_q    <= sum2_d;
      len_q     <= len_d;
      count_q   <= count_d;
      acid_q    <= acid_d;
      msgid_q   <= msgid_d;
      pending_q <= pending_d;
      err_q     <= err_d;
      ovr_q     <= ovr_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
    end
  end

  `TFP_ASSERT(a_good_sets_pending, fire_i && (ev == EV_GOOD) |=> pending_q, "good frame did not set pending")
  `TFP_ASSERT(a_err_monotonic, 1'b1 |-> (err_q >= $past(err_q)), "error count went down")
  `TFP_ASSERT_NEVER(a_ovr_le_err, ovr_q > err_q, "overrun count above error count")
  `TFP_ASSERT(a_wait_needs_start, fire_i && (state_q == ST_WAIT) && (rx != start_q) |=> state_q == ST_WAIT, "left wait without start byte")

endmodule

// ===== sv/tfp_out_reg.sv =====
// result register stage of the telemetry frame parser
`timescale 1ns / 1ps

module tfp_out_reg import tfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  result_t res_i,
  output logic    out_ready_o,
  output logic    out_valid_o,
  input  logic    out_taken_i,
  output result_t res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign out_ready_o = !vld_q || out_taken_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_comb begin
    vld_d = vld_q;
    if (fire_i) begin
      vld_d = 1'b1;
    end else if (out_taken_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== sv/telemetry_frame_parser_unit.sv =====
// top level of the telemetry frame parser
`timescale 1ns / 1ps

// Deframes a byte stream of frames (start byte, total length, aircraft id,
// message id, payload, two Fletcher-style check bytes) and gives one result
// item for every input item: a payload byte with its index, frame good,
// checksum error, overrun, bad length, or none, along with the current frame
// fields, the pending flag and the saturating error counters. One item is
// taken every clock cycle while m_axis_tready accepts results: an input
// register feeds the parser logic, whose result lands in an output register,
// so s_axis_tready stays high while that output register is empty or being
// drained. The start byte register may be written only while the block idles.
module telemetry_frame_parser_unit import tfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // rx_byte
  input  logic [InUserW-1:0]  s_axis_tuser,   // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // payload_byte, payload_index, aircraft_id, message_id, payload_length,
  // pending, error_total, overrun_total, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [OutUserW-1:0] m_axis_tuser    // event_res
);

  item_t   in_item, item;
  result_t res, res_q;
  logic    fire, out_ready;

  assign in_item.action  = s_axis_tuser[0];
  assign in_item.rx_byte = s_axis_tdata[ByteW-1:0];

  tfp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_ready_i (out_ready),
    .fire_o      (fire),
    .item_o      (item)
  );

  tfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_o       (res)
  );

  tfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .out_ready_o (out_ready),
    .out_valid_o (m_axis_tvalid),
    .out_taken_i (m_axis_tready),
    .res_o       (res_q)
  );

  assign m_axis_tuser = res_q.event_res;
  assign m_axis_tdata = {7'd0,
                         res_q.overrun_total,
                         res_q.error_total,
                         res_q.pending,
                         res_q.payload_length,
                         res_q.message_id,
                         res_q.aircraft_id,
                         res_q.payload_index,
                         res_q.payload_byte};

endmodule
